@@ hdl/assert_macros.svh @@
// Assertion macros shared by the trace number extractor RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define TNE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Expression never true at a clock edge outside reset.
`define TNE_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define TNE_ASSERT(lbl, clk, rst_n, prop)
`define TNE_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ hdl/tne_pkg.sv @@
// Shared types, phase codes and helper functions of the trace number extractor.
// No dependencies; used by the parser, result register and top level.
`timescale 1ns / 1ps

package tne_pkg;

	localparam int MaxMessageBytes = 4096;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_BITMAP = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_LEN_LO = 3'd4;
	localparam logic [2:0] PH_TRACE  = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	localparam logic [3:0] LLVAR_FIELD     = 4'd2;
	localparam logic [3:0] LAST_SKIP_FIELD = 4'd10;
	localparam logic [3:0] NO_FIELD        = 4'd11;
	localparam logic [2:0] TRACE_DIGITS    = 3'd6;

	typedef struct packed {
		logic        valid;
		logic [19:0] trace_number;
		logic        status;
	} result_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	// Fixed length of fields 1..10; the LLVAR field has no fixed length.
	function automatic logic [6:0] fixed_len(input logic [3:0] field);
		logic [6:0] len;
		case (field)
			4'd1:    len = 7'd8;
			4'd3:    len = 7'd6;
			4'd4:    len = 7'd12;
			4'd5:    len = 7'd12;
			4'd6:    len = 7'd12;
			4'd7:    len = 7'd10;
			4'd8:    len = 7'd8;
			4'd9:    len = 7'd8;
			4'd10:   len = 7'd8;
			default: len = 7'd0;
		endcase
		return len;
	endfunction

	// First field at or after start whose bitmap bit is set; NO_FIELD if none.
	function automatic logic [3:0] next_present(input logic [15:0] bm, input logic [3:0] start);
		logic [3:0] found;
		logic       hit;
		found = NO_FIELD;
		hit   = 1'b0;
		for (int k = 1; k <= 10; k++) begin
			if (!hit && (4'(k) >= start) && bm[16 - k]) begin
				found = 4'(k);
				hit   = 1'b1;
			end
		end
		return found;
	endfunction

endpackage

@@ hdl/tne_parser.sv @@
// Input register and per-byte message parser of the trace number extractor.
// Depends on tne_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tne_parser #(
	parameter int MAX_MESSAGE_BYTES = tne_pkg::MaxMessageBytes
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       msg_byte,
	input  logic             end_of_message,
	input  logic             res_ready,
	output tne_pkg::result_t res
);

	localparam int OFS_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_MESSAGE_BYTES);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;
	logic       fire;

	logic [2:0]       phase_q,   n_phase;
	logic [OFS_W-1:0] ofs_q,     n_ofs;
	logic [15:0]      bitmap_q,  n_bitmap;
	logic [3:0]       field_q,   n_field;
	logic [6:0]       skip_q,    n_skip;
	logic [6:0]       lpv_q,     n_lpv;
	logic [19:0]      acc_q,     n_acc;
	logic [2:0]       digits_q,  n_digits;
	logic             ended_q,   n_ended;

	logic       do_enter;
	logic [3:0] enter_start;
	logic [3:0] nf;
	logic [3:0] dval;

	assign fire     = valid_s1 && (!eom_s1 || res_ready);
	assign in_stall = valid_s1 && !fire;
	assign dval     = byte_s1[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= msg_byte;
			eom_s1  <= end_of_message;
		end
	end

	always_comb begin
		n_phase     = phase_q;
		n_ofs       = ofs_q;
		n_bitmap    = bitmap_q;
		n_field     = field_q;
		n_skip      = skip_q;
		n_lpv       = lpv_q;
		n_acc       = acc_q;
		n_digits    = digits_q;
		n_ended     = ended_q;
		do_enter    = 1'b0;
		enter_start = field_q;
		nf          = tne_pkg::NO_FIELD;

		if (fire && (ofs_q < OFS_MAX)) begin
			n_ofs = ofs_q + OFS_W'(1);
			case (phase_q)
				tne_pkg::PH_HEADER: begin
					if (ofs_q == OFS_W'(3))
						n_phase = tne_pkg::PH_BITMAP;
				end
				tne_pkg::PH_BITMAP: begin
					if (ofs_q == OFS_W'(4))
						n_bitmap = {byte_s1, 8'h00};
					else if (ofs_q == OFS_W'(5))
						n_bitmap = {bitmap_q[15:8], byte_s1};
					if (ofs_q == OFS_W'(11)) begin
						do_enter    = 1'b1;
						enter_start = 4'd1;
					end
				end
				tne_pkg::PH_SKIP: begin
					if (skip_q != 7'd0)
						n_skip = skip_q - 7'd1;
					if (n_skip == 7'd0) begin
						do_enter    = 1'b1;
						enter_start = field_q + 4'd1;
					end
				end
				tne_pkg::PH_LEN_HI: begin
					if (tne_pkg::is_digit(byte_s1)) begin
						n_lpv   = {3'd0, dval};
						n_ended = 1'b0;
					end else begin
						n_lpv   = 7'd0;
						n_ended = 1'b1;
					end
					n_phase = tne_pkg::PH_LEN_LO;
				end
				tne_pkg::PH_LEN_LO: begin
					if (!ended_q && tne_pkg::is_digit(byte_s1))
						n_lpv = 7'(lpv_q * 7'd10) + {3'd0, dval};
					n_ended = 1'b0;
					n_skip  = n_lpv;
					if (n_lpv == 7'd0) begin
						do_enter    = 1'b1;
						enter_start = field_q + 4'd1;
					end else begin
						n_phase = tne_pkg::PH_SKIP;
					end
				end
				tne_pkg::PH_TRACE: begin
					if (!ended_q && tne_pkg::is_digit(byte_s1))
						n_acc = 20'(acc_q * 20'd10) + {16'd0, dval};
					else
						n_ended = 1'b1;
					n_digits = digits_q + 3'd1;
					if (n_digits >= tne_pkg::TRACE_DIGITS)
						n_phase = tne_pkg::PH_DONE;
				end
				default: begin
				end
			endcase

			if (do_enter) begin
				nf      = tne_pkg::next_present(n_bitmap, enter_start);
				n_field = nf;
				if (nf == tne_pkg::NO_FIELD) begin
					n_phase  = tne_pkg::PH_TRACE;
					n_digits = 3'd0;
					n_ended  = 1'b0;
					n_acc    = 20'd0;
				end else if (nf == tne_pkg::LLVAR_FIELD) begin
					n_phase = tne_pkg::PH_LEN_HI;
				end else begin
					n_phase = tne_pkg::PH_SKIP;
					n_skip  = tne_pkg::fixed_len(nf);
				end
			end
		end

		res.valid        = fire && eom_s1;
		res.trace_number = n_acc;
		res.status       = (n_phase != tne_pkg::PH_DONE);

		// close the message: drop all state back to its start values
		if (fire && eom_s1) begin
			n_phase  = tne_pkg::PH_HEADER;
			n_ofs    = '0;
			n_bitmap = 16'd0;
			n_field  = 4'd1;
			n_skip   = 7'd0;
			n_lpv    = 7'd0;
			n_acc    = 20'd0;
			n_digits = 3'd0;
			n_ended  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tne_pkg::PH_HEADER;
			ofs_q    <= '0;
			bitmap_q <= 16'd0;
			field_q  <= 4'd1;
			skip_q   <= 7'd0;
			lpv_q    <= 7'd0;
			acc_q    <= 20'd0;
			digits_q <= 3'd0;
			ended_q  <= 1'b0;
		end else begin
			phase_q  <= n_phase;
			ofs_q    <= n_ofs;
			bitmap_q <= n_bitmap;
			field_q  <= n_field;
			skip_q   <= n_skip;
			lpv_q    <= n_lpv;
			acc_q    <= n_acc;
			digits_q <= n_digits;
			ended_q  <= n_ended;
		end
	end

	`TNE_ASSERT(a_trace_past_fields, clk, arst_n, (phase_q == tne_pkg::PH_TRACE || phase_q == tne_pkg::PH_DONE) |-> field_q == tne_pkg::NO_FIELD)
	`TNE_ASSERT(a_done_six_digits, clk, arst_n, phase_q == tne_pkg::PH_DONE |-> digits_q == tne_pkg::TRACE_DIGITS)
	`TNE_ASSERT(a_stall_only_on_eom, clk, arst_n, in_stall |-> (valid_s1 && eom_s1 && !res_ready))

endmodule

@@ hdl/tne_result_reg.sv @@
// Output register of the trace number extractor: holds one result word.
// Depends on tne_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tne_result_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  tne_pkg::result_t res,
	output logic             res_ready,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [19:0]      trace_number,
	output logic             status
);

	logic        out_valid_q;
	logic [19:0] trace_q;
	logic        status_q;

	assign res_ready    = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign trace_number = trace_q;
	assign status       = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	// load payload only on a new word; hold it while stalled
	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			trace_q  <= res.trace_number;
			status_q <= res.status;
		end
	end

	`TNE_NEVER(a_no_lost_result, clk, arst_n, res.valid && !res_ready)

endmodule

@@ hdl/iso8583_trace_number_extractor.sv @@
// Result path: the last byte of a message passes from the input stage through the parser
// into the output register, and out_valid rises when that register is loaded.
// Throughput: one message byte per cycle; only an end-of-message byte waits in
// the input stage, while the previous result is still held in the output register.
// Per-byte parsing is combinational between the input stage and the result register.
// Reset (arst_n low) clears all parser state and both valid flags at once.
`timescale 1ns / 1ps

module iso8583_trace_number_extractor #(
	parameter int MAX_MESSAGE_BYTES = tne_pkg::MaxMessageBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] trace_number,
	output logic        status
);

	tne_pkg::result_t res;
	logic             res_ready;

	tne_parser #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.msg_byte       (msg_byte),
		.end_of_message (end_of_message),
		.res_ready      (res_ready),
		.res            (res)
	);

	tne_result_reg u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.res_ready    (res_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.trace_number (trace_number),
		.status       (status)
	);

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for iso8583_trace_number_extractor: directed words, then random messages.
// Depends on tne_pkg (phase codes, field limits) and the extractor RTL; needs no files.
`timescale 1ns / 1ps

module testbench;
	import tne_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_WORDS  = 1600;
	localparam int MIN_MESSAGES  = 30;
	localparam int MSG_LIMIT     = 256;
	localparam int HOLD_AFTER    = 3;
	localparam int LONG_HOLD     = 1500;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HEADER_LAST   = 3;
	localparam int MAP_HI_POS    = 4;
	localparam int MAP_LO_POS    = 5;
	localparam int MAP_LAST      = 11;

	localparam logic STATUS_COMPLETE  = 1'b0;
	localparam logic STATUS_TRUNCATED = 1'b1;

	localparam logic [6:0] FIELD_LENGTH [1:10] = '{
		7'd8, 7'd0, 7'd6, 7'd12, 7'd12, 7'd12, 7'd10, 7'd8, 7'd8, 7'd8
	};

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [19:0] tn;
		logic        st;
	} word_t;

	typedef struct packed {
		logic [19:0] tn;
		logic        st;
	} trace_result_t;

	// Lone-byte messages, an empty-bitmap message with the largest trace number,
	// and a message cut inside the bitmap.
	localparam word_t DIRECTED_WORDS [25] = '{
		'{8'hFF, 1'b1, 1'b1, 20'd0, STATUS_TRUNCATED},
		'{8'h00, 1'b1, 1'b1, 20'd0, STATUS_TRUNCATED},
		'{8'hFF, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h00, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'hFF, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h00, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h00, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h00, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'hFF, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'hFF, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'hFF, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'hFF, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'hFF, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'hFF, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h39, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h39, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h39, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h39, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h39, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h39, 1'b1, 1'b1, 20'd999999, STATUS_COMPLETE},
		'{8'h30, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h31, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h32, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h33, 1'b0, 1'b0, 20'd0, STATUS_COMPLETE},
		'{8'h80, 1'b1, 1'b1, 20'd0, STATUS_TRUNCATED}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  msg_byte = 8'h00;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [19:0] trace_number;
	logic        status;

	word_t         words[$];
	logic [7:0]    msg[$];
	trace_result_t pending_results[$];
	int            errors = 0;
	int            results_checked = 0;
	int            messages_built = 0;
	int            cycle_count = 0;

	// Parser state of the predictor.
	logic [2:0]  parse_phase;
	int unsigned byte_pos;
	logic [15:0] field_map;
	logic [3:0]  field_num;
	logic [6:0]  bytes_to_skip;
	logic [6:0]  llvar_len;
	logic [19:0] trace_value;
	logic [2:0]  trace_digits;
	logic        run_broken;

	iso8583_trace_number_extractor #(
		.MAX_MESSAGE_BYTES(MSG_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.msg_byte(msg_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trace_number(trace_number),
		.status(status)
	);

	always #5 clk = ~clk;

	function automatic logic ascii_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] odd_byte();
		logic [7:0] c;
		case ($urandom_range(0, 5))
			0: c = " ";
			1: c = "+";
			2: c = "-";
			3: c = "/";
			4: c = ":";
			default: begin
				do c = 8'($urandom); while (ascii_digit(c));
			end
		endcase
		return c;
	endfunction

	task automatic clear_parser();
		parse_phase   = PH_HEADER;
		byte_pos      = 0;
		field_map     = '0;
		field_num     = 4'd1;
		bytes_to_skip = '0;
		llvar_len     = '0;
		trace_value   = '0;
		trace_digits  = '0;
		run_broken    = 1'b0;
	endtask

	// Advance to the next field whose bitmap bit is set, or to the trace number.
	task automatic open_next_field();
		while (field_num <= LAST_SKIP_FIELD && !field_map[16 - field_num])
			field_num++;
		if (field_num > LAST_SKIP_FIELD) begin
			parse_phase  = PH_TRACE;
			trace_digits = '0;
			run_broken   = 1'b0;
			trace_value  = '0;
		end else if (field_num == LLVAR_FIELD) begin
			parse_phase = PH_LEN_HI;
		end else begin
			parse_phase   = PH_SKIP;
			bytes_to_skip = FIELD_LENGTH[field_num];
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		case (parse_phase)
			PH_HEADER: begin
				if (byte_pos == HEADER_LAST)
					parse_phase = PH_BITMAP;
			end
			PH_BITMAP: begin
				if (byte_pos == MAP_HI_POS)
					field_map = {b, 8'h00};
				else if (byte_pos == MAP_LO_POS)
					field_map[7:0] = b;
				if (byte_pos == MAP_LAST) begin
					field_num = 4'd1;
					open_next_field();
				end
			end
			PH_SKIP: begin
				if (bytes_to_skip > 0)
					bytes_to_skip--;
				if (bytes_to_skip == 0) begin
					field_num++;
					open_next_field();
				end
			end
			PH_LEN_HI: begin
				if (ascii_digit(b)) begin
					llvar_len  = 7'(b - "0");
					run_broken = 1'b0;
				end else begin
					llvar_len  = '0;
					run_broken = 1'b1;
				end
				parse_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (!run_broken && ascii_digit(b))
					llvar_len = 7'(llvar_len * 10 + (b - "0"));
				run_broken    = 1'b0;
				bytes_to_skip = llvar_len;
				if (bytes_to_skip == 0) begin
					field_num++;
					open_next_field();
				end else begin
					parse_phase = PH_SKIP;
				end
			end
			PH_TRACE: begin
				if (!run_broken && ascii_digit(b))
					trace_value = 20'(trace_value * 10 + (b - "0"));
				else
					run_broken = 1'b1;
				trace_digits++;
				if (trace_digits >= TRACE_DIGITS)
					parse_phase = PH_DONE;
			end
			default: ;
		endcase
	endtask

	// Update the predictor with one accepted word; queue the result it causes.
	task automatic predict_word(input word_t w);
		trace_result_t res;
		if (byte_pos < MSG_LIMIT) begin
			parse_byte(w.data);
			byte_pos++;
		end
		if (w.last) begin
			res.tn = trace_value;
			res.st = (parse_phase == PH_DONE) ? STATUS_COMPLETE : STATUS_TRUNCATED;
			if (w.typed) begin
				res.tn = w.tn;
				res.st = w.st;
			end
			pending_results.push_back(res);
			clear_parser();
		end
	endtask

	task automatic flush_message();
		word_t w;
		foreach (msg[i]) begin
			w = '{data: msg[i], last: (i == msg.size() - 1), typed: 1'b0,
				tn: 20'd0, st: STATUS_COMPLETE};
			words.push_back(w);
		end
		msg.delete();
		messages_built++;
	endtask

	task automatic build_wellformed();
		logic [15:0] map;
		logic [7:0]  c_hi;
		logic [7:0]  c_lo;
		int          len;
		int          stop;
		msg.delete();
		repeat (4) msg.push_back(8'($urandom));
		map = 16'($urandom & $urandom);
		msg.push_back(map[15:8]);
		msg.push_back(map[7:0]);
		repeat (6) msg.push_back(8'($urandom));
		for (int k = 1; k <= 10; k++) begin
			if (!map[16 - k])
				continue;
			if (k == LLVAR_FIELD) begin
				case ($urandom_range(0, 9))
					0: begin
						// no leading digit: length reads as zero
						len  = 0;
						c_hi = odd_byte();
						c_lo = 8'($urandom);
					end
					1: begin
						len  = $urandom_range(0, 9);
						c_hi = 8'("0" + len);
						c_lo = odd_byte();
					end
					default: begin
						len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
							: $urandom_range(0, 12);
						c_hi = 8'("0" + len / 10);
						c_lo = 8'("0" + len % 10);
					end
				endcase
				msg.push_back(c_hi);
				msg.push_back(c_lo);
				repeat (len) msg.push_back(8'($urandom));
			end else begin
				repeat (FIELD_LENGTH[k]) msg.push_back(8'($urandom));
			end
		end
		stop = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 6;
		for (int i = 0; i < 6; i++)
			msg.push_back((i == stop) ? odd_byte() : 8'("0" + $urandom_range(0, 9)));
		repeat ($urandom_range(0, 4)) msg.push_back(8'($urandom));
	endtask

	task automatic build_stimulus();
		int pick;
		int pad;
		foreach (DIRECTED_WORDS[i])
			words.push_back(DIRECTED_WORDS[i]);
		while (words.size() < RANDOM_WORDS || messages_built < MIN_MESSAGES) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				build_wellformed();
			end else if (pick < 18) begin
				build_wellformed();
				msg = msg[0:$urandom_range(0, msg.size() - 2)];
			end else begin
				msg.delete();
				repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom));
			end
			flush_message();
		end
		// One message past the offset limit: the counter must saturate.
		build_wellformed();
		pad = MSG_LIMIT + $urandom_range(1, 8);
		while (msg.size() < pad)
			msg.push_back(8'($urandom));
		flush_message();
	endtask

	task automatic send_words();
		word_t w;
		int    gap;
		int    quiet;
		quiet = 0;
		while (words.size() > 0) begin
			w = words.pop_front();
			if (quiet == 0 && $urandom_range(0, 15) == 0)
				quiet = $urandom_range(8, 40);
			if (quiet > 0) begin
				gap = 0;
				quiet--;
			end else begin
				gap = $urandom_range(0, 5);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid       <= 1'b1;
			msg_byte       <= w.data;
			end_of_message <= w.last;
			do @(posedge clk); while (in_stall);
			predict_word(w);
		end
		in_valid <= 1'b0;
	endtask

	initial begin : result_sink
		int stall_cycles;
		int quiet;
		int taken;
		quiet = 0;
		taken = 0;
		@(posedge clk iff arst_n);
		forever begin
			if (taken == HOLD_AFTER) begin
				// hold off long enough for the input side to back up
				stall_cycles = LONG_HOLD;
			end else if (quiet > 0) begin
				stall_cycles = 0;
				quiet--;
			end else begin
				stall_cycles = $urandom_range(0, 5);
				if ($urandom_range(0, 7) == 0)
					quiet = $urandom_range(5, 15);
			end
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		trace_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got trace_number %0d status %0d",
					$time, trace_number, status);
			end else begin
				want = pending_results.pop_front();
				if (trace_number !== want.tn) begin
					errors++;
					$display("%0t: trace_number mismatch, expected %0d, got %0d",
						$time, want.tn, trace_number);
				end
				if (status !== want.st) begin
					errors++;
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.st, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int total_words;
		clear_parser();
		build_stimulus();
		total_words = words.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_words();
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d message bytes in %0d messages (lone bytes, cut, overlong, LLVAR).",
			total_words, messages_built + 4);
		$display("Checked %0d results with %0d field mismatches.", results_checked, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
